// ----- rtl/rsi_pkg.sv -----
package rsi_pkg;

    // fraction bits of the direction components
    localparam int DIR_FRAC = 14;

    // field widths of a transaction
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 13;
    localparam int DIST_W   = 18;

    // internal widths
    localparam int OFS_W    = COORD_W + 1;          // origin minus center
    localparam int PROD_W   = OFS_W + COORD_W;      // one term of the dot product
    localparam int SQ_W     = 2 * COORD_W;          // one squared offset, nonnegative
    localparam int RR_W     = 2 * RADIUS_W;         // radius squared
    localparam int SUM_W    = PROD_W + 2;           // dot product and |o|^2 - r^2
    localparam int HB_W     = 20;                   // half-b term
    localparam int HBSQ_W   = 38;                   // half-b squared, nonnegative
    localparam int DISC_W   = 40;                   // discriminant
    localparam int ROOT_W   = DISC_W / 2;           // floor square root
    localparam int REM_W    = ROOT_W + 2;           // square root partial remainder
    localparam int T_W      = HB_W + 2;             // root of the quadratic

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // data that rides alongside the square root
    typedef struct packed {
        logic signed [HB_W-1:0] hb;
        logic                   miss;
    } t_side;

endpackage

// ----- rtl/rsi_intf.sv -----
interface rsi_ray_if import rsi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic signed [COORD_W-1:0]  origin_z;
    logic signed [COORD_W-1:0]  dir_x;
    logic signed [COORD_W-1:0]  dir_y;
    logic signed [COORD_W-1:0]  dir_z;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic [RADIUS_W-1:0]        sphere_radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

interface rsi_hit_if import rsi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [DIST_W-1:0]  distance;

    modport source (output valid, hit, distance, input ready);
    modport sink (input valid, hit, distance, output ready);
endinterface

// ----- rtl/rsi_sqrt.sv -----
module rsi_sqrt import rsi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [DISC_W-1:0]   i_rad,
    input  t_side               i_side,
    output logic                o_rdy,
    output logic                o_vld,
    output logic [ROOT_W-1:0]   o_root,
    output t_side               o_side,
    input  logic                i_rdy
);

    localparam int NS = ROOT_W;

    typedef struct packed {
        logic [DISC_W-1:0]  rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        t_side              side;
    } t_sq_stage;

    // one restoring digit: two radicand bits in, one root bit out
    function automatic t_sq_stage sq_step(input t_sq_stage a);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        t_sq_stage        b;
        b     = a;
        cur   = {a.rem, a.rad[DISC_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W){1'b0}}, a.root, 2'b01};
        b.rad = {a.rad[DISC_W-3:0], 2'b00};
        if (cur >= trial) begin
            b.rem  = REM_W'(cur - trial);
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = cur[REM_W-1:0];
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    t_sq_stage          r_st [NS];
    t_sq_stage          n_st [NS];
    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      adv;
    t_sq_stage          entry;

    // stage moves when empty or when the stage after it moves
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_rdy = adv[0];

    // next value of every digit stage
    always_comb begin
        entry.rad  = i_rad;
        entry.rem  = '0;
        entry.root = '0;
        entry.side = i_side;
        n_st[0] = sq_step(entry);
        for (int k = 1; k < NS; k++) begin
            n_st[k] = sq_step(r_st[k-1]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_st[NS-1].root;
    assign o_side = r_st[NS-1].side;

endmodule

// ----- rtl/ray_sphere_intersect_unit.sv -----
// channel   modport   role
// i_ray     sink      ray origin, direction, sphere center and radius in
// o_hit     source    hit flag and distance, one transaction per ray
//
// accept to result valid: five arithmetic stages, one square root stage per
// root bit (20), and the output register; the sqrt pipeline sets the depth.
// a new ray is taken every cycle unless every stage is full and blocked.
// i_rst_n is synchronous and clears only the valid bits of every stage.
// each stage holds while full and blocked, so a stall on o_hit fills the
// empty stages first and i_ray.ready falls only once every stage is full.
module ray_sphere_intersect_unit import rsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsi_ray_if.sink     i_ray,
    rsi_hit_if.source   o_hit
);

    localparam int NF = 5;

    logic [NF-1:0] r_vld;
    logic [NF-1:0] adv;
    logic          sq_rdy;
    logic          sq_vld;
    logic          out_adv;
    logic [ROOT_W-1:0] sq_root;
    t_side         sq_side;

    // stage 1: offsets
    logic signed [OFS_W-1:0]   r1_ox, r1_oy, r1_oz;
    logic signed [COORD_W-1:0] r1_dx, r1_dy, r1_dz;
    logic [RADIUS_W-1:0]       r1_r;
    // stage 2: products
    logic signed [PROD_W-1:0]  r2_px, r2_py, r2_pz;
    logic [SQ_W-1:0]           r2_sx, r2_sy, r2_sz;
    logic [RR_W-1:0]           r2_rr;
    // stage 3: half-b and c
    logic signed [HB_W-1:0]    r3_hb;
    logic signed [SUM_W-1:0]   r3_c;
    // stage 4: half-b squared
    logic signed [HB_W-1:0]    r4_hb;
    logic [HBSQ_W-1:0]         r4_hbsq;
    logic signed [SUM_W-1:0]   r4_c;
    // stage 5: discriminant
    logic [DISC_W-1:0]         r5_rad;
    t_side                     r5_side;
    // output register
    logic                      r_out_vld;
    logic                      r_out_hit;
    logic [DIST_W-1:0]         r_out_dist;

    logic signed [PROD_W-1:0]   n2_px, n2_py, n2_pz;
    logic [SQ_W-1:0]            sqx_full, sqy_full, sqz_full;
    logic [RR_W-1:0]            n2_rr;
    logic signed [SUM_W-1:0]    dot;
    logic [SUM_W-2:0]           sq_sum;
    logic signed [SUM_W-1:0]    n3_c;
    logic [HBSQ_W-1:0]          hbsq_full;
    logic signed [DISC_W-1:0]   disc;
    logic signed [T_W-1:0]      t_near, t_far, t_sel;
    logic                       n_hit;
    logic [DIST_W-1:0]          n_dist;

    // handshake: a stage moves when empty or when the next one moves
    assign out_adv = !r_out_vld || o_hit.ready;

    always_comb begin
        adv[NF-1] = !r_vld[NF-1] || sq_rdy;
        for (int k = NF - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_ray.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_ray.valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (out_adv) begin
                r_out_vld <= sq_vld;
            end
        end
    end

    // stage 2 and 3 arithmetic
    assign n2_px    = r1_ox * r1_dx;
    assign n2_py    = r1_oy * r1_dy;
    assign n2_pz    = r1_oz * r1_dz;
    assign sqx_full = r1_ox * r1_ox;
    assign sqy_full = r1_oy * r1_oy;
    assign sqz_full = r1_oz * r1_oz;
    assign n2_rr    = r1_r * r1_r;

    assign dot    = SUM_W'(r2_px) + SUM_W'(r2_py) + SUM_W'(r2_pz);
    assign sq_sum = (SUM_W-1)'(r2_sx) + (SUM_W-1)'(r2_sy) + (SUM_W-1)'(r2_sz);
    assign n3_c   = $signed({1'b0, sq_sum}) - $signed(SUM_W'(r2_rr));

    // stage 4 and 5 arithmetic
    assign hbsq_full = r3_hb * r3_hb;
    assign disc      = $signed({{(DISC_W-HBSQ_W){1'b0}}, r4_hbsq}) - DISC_W'(r4_c);

    // arithmetic pipeline data
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_ox <= OFS_W'(i_ray.origin_x) - OFS_W'(i_ray.center_x);
            r1_oy <= OFS_W'(i_ray.origin_y) - OFS_W'(i_ray.center_y);
            r1_oz <= OFS_W'(i_ray.origin_z) - OFS_W'(i_ray.center_z);
            r1_dx <= i_ray.dir_x;
            r1_dy <= i_ray.dir_y;
            r1_dz <= i_ray.dir_z;
            r1_r  <= i_ray.sphere_radius;
        end
        if (adv[1]) begin
            r2_px <= n2_px;
            r2_py <= n2_py;
            r2_pz <= n2_pz;
            r2_sx <= sqx_full[SQ_W-1:0];
            r2_sy <= sqy_full[SQ_W-1:0];
            r2_sz <= sqz_full[SQ_W-1:0];
            r2_rr <= n2_rr;
        end
        if (adv[2]) begin
            r3_hb <= HB_W'(dot >>> DIR_FRAC);
            r3_c  <= n3_c;
        end
        if (adv[3]) begin
            r4_hb   <= r3_hb;
            r4_hbsq <= hbsq_full[HBSQ_W-1:0];
            r4_c    <= r3_c;
        end
        if (adv[4]) begin
            r5_rad       <= disc[DISC_W-1] ? '0 : DISC_W'(disc);
            r5_side.hb   <= r4_hb;
            r5_side.miss <= disc[DISC_W-1];
        end
    end

    // floor square root of the discriminant
    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[NF-1]),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_rdy   (sq_rdy),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side),
        .i_rdy   (out_adv)
    );

    // near root, else far root, then saturate
    always_comb begin
        t_near = -T_W'(sq_side.hb) - $signed({{(T_W-ROOT_W){1'b0}}, sq_root});
        t_far  = -T_W'(sq_side.hb) + $signed({{(T_W-ROOT_W){1'b0}}, sq_root});
        t_sel  = t_near[T_W-1] ? t_far : t_near;
        n_hit  = !sq_side.miss && !t_sel[T_W-1];
        if (!n_hit) begin
            n_dist = '0;
        end else if (|t_sel[T_W-2:DIST_W]) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = t_sel[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_hit  <= n_hit;
            r_out_dist <= n_dist;
        end
    end

    assign o_hit.valid    = r_out_vld;
    assign o_hit.hit      = r_out_hit;
    assign o_hit.distance = r_out_dist;

endmodule

// ----- test/intersect_compare.sv -----
`timescale 1ns / 100ps

module intersect_compare import rsi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rsi_ray_if      i_ray,
    rsi_hit_if      i_hit,
    output int      o_mismatches,
    output int      o_pending,
    output int      o_checked,
    output int      o_hits
);

    localparam longint DIST_TOP = (longint'(1) << DIST_W) - 1;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } t_hit_result;

    t_hit_result expected_hits[$];
    int          mismatch_cnt = 0;
    int          pending_cnt  = 0;
    int          checked_cnt  = 0;
    int          hit_cnt      = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_cnt;
    assign o_hits       = hit_cnt;

    // digit by digit floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned weight;
        rem    = n;
        root   = 0;
        weight = longint'(1) << 62;
        while (weight > rem) begin
            weight = weight >> 2;
        end
        while (weight != 0) begin
            if (rem >= root + weight) begin
                rem  = rem - (root + weight);
                root = (root >> 1) + weight;
            end else begin
                root = root >> 1;
            end
            weight = weight >> 2;
        end
        return root;
    endfunction

    // exact integer ray / sphere test, near root first, far root when the near one is behind
    function automatic t_hit_result predict_intersection(
        input logic signed [COORD_W-1:0] org_x, org_y, org_z,
        input logic signed [COORD_W-1:0] dir_x, dir_y, dir_z,
        input logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z,
        input logic [RADIUS_W-1:0]       radius
    );
        longint      ofs_x, ofs_y, ofs_z;
        longint      dot, half_b, c_term, disc, root, t;
        longint      rad;
        t_hit_result res;
        res.hit      = 1'b0;
        res.distance = '0;
        ofs_x  = longint'(org_x) - longint'(ctr_x);
        ofs_y  = longint'(org_y) - longint'(ctr_y);
        ofs_z  = longint'(org_z) - longint'(ctr_z);
        rad    = longint'(radius);
        dot    = ofs_x * longint'(dir_x) + ofs_y * longint'(dir_y) + ofs_z * longint'(dir_z);
        // arithmetic shift floors toward minus infinity
        half_b = dot >>> DIR_FRAC;
        c_term = ofs_x * ofs_x + ofs_y * ofs_y + ofs_z * ofs_z - rad * rad;
        disc   = half_b * half_b - c_term;
        if (disc < 0) begin
            return res;
        end
        root = longint'(floor_sqrt(disc));
        t = -half_b - root;
        if (t < 0) begin
            t = -half_b + root;
        end
        if (t < 0) begin
            return res;
        end
        if (t > DIST_TOP) begin
            t = DIST_TOP;
        end
        res.hit      = 1'b1;
        res.distance = t[DIST_W-1:0];
        return res;
    endfunction

    // compare each result transaction, then predict each accepted ray
    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n) begin
            if (i_hit.valid && i_hit.ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b distance=%0d",
                             $time, i_hit.hit, i_hit.distance);
                    mismatch_cnt++;
                end else begin
                    want = expected_hits.pop_front();
                    checked_cnt++;
                    if (want.hit) begin
                        hit_cnt++;
                    end
                    if (i_hit.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want.hit, i_hit.hit);
                        mismatch_cnt++;
                    end
                    if (i_hit.distance !== want.distance) begin
                        $display("%0t: distance mismatch, expected %0d, actual %0d",
                                 $time, want.distance, i_hit.distance);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_ray.valid && i_ray.ready) begin
                expected_hits.push_back(predict_intersection(
                    i_ray.origin_x, i_ray.origin_y, i_ray.origin_z,
                    i_ray.dir_x, i_ray.dir_y, i_ray.dir_z,
                    i_ray.center_x, i_ray.center_y, i_ray.center_z,
                    i_ray.sphere_radius));
            end
            pending_cnt = expected_hits.size();
        end
    end

endmodule

// ----- test/tb_ray_sphere_intersect_unit.sv -----
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_unit;
    import rsi_pkg::*;

    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum int {RAY_AIMED, RAY_INSIDE, RAY_BEHIND, RAY_NOISE} ray_kind_e;

    // same field order as the concatenation driven onto the ray channel
    typedef struct packed {
        logic signed [COORD_W-1:0] org_x, org_y, org_z;
        logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
        logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
        logic [RADIUS_W-1:0]       radius;
    } ray_t;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    bit   long_hold_req = 1'b0;
    int   rays_sent     = 0;
    int   quiet_cycles;
    int   mismatches;
    int   pending;
    int   checked;
    int   hits;

    rsi_ray_if ray_ch ();
    rsi_hit_if hit_ch ();

    ray_sphere_intersect_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch),
        .o_hit   (hit_ch)
    );

    intersect_compare u_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ray        (ray_ch),
        .i_hit        (hit_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side ready, with an optional long hold-off
    initial begin
        hit_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                hit_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            hit_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: timeout after %0d cycles without a transaction", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] clamp_coord(input real v);
        if (v > 32767.0) begin
            return 16'sh7fff;
        end
        if (v < -32768.0) begin
            return 16'sh8000;
        end
        return COORD_W'($rtoi(v));
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic ray_t mk_ray(input int ox, oy, oz, dx, dy, dz, cx, cy, cz, rad);
        ray_t r;
        r.org_x  = COORD_W'(ox);
        r.org_y  = COORD_W'(oy);
        r.org_z  = COORD_W'(oz);
        r.dir_x  = COORD_W'(dx);
        r.dir_y  = COORD_W'(dy);
        r.dir_z  = COORD_W'(dz);
        r.ctr_x  = COORD_W'(cx);
        r.ctr_y  = COORD_W'(cy);
        r.ctr_z  = COORD_W'(cz);
        r.radius = RADIUS_W'(rad);
        return r;
    endfunction

    // mostly rays aimed at the sphere, some from inside, some away from it, some raw noise
    function automatic ray_t random_ray();
        ray_kind_e   kind;
        int          pick;
        int          rad;
        int          ox, oy, oz;
        real         ux, uy, uz, norm, reach;
        logic [191:0] raw;
        ray_t        r;
        pick = $urandom_range(99);
        kind = (pick < 55) ? RAY_AIMED : (pick < 70) ? RAY_INSIDE :
               (pick < 80) ? RAY_BEHIND : RAY_NOISE;
        do begin
            ux   = real'(int'($urandom_range(2000)) - 1000);
            uy   = real'(int'($urandom_range(2000)) - 1000);
            uz   = real'(int'($urandom_range(2000)) - 1000);
            norm = $sqrt(ux * ux + uy * uy + uz * uz);
        end while (norm < 1.0);
        ux  = ux / norm;
        uy  = uy / norm;
        uz  = uz / norm;
        rad = ($urandom_range(2) == 0) ? int'($urandom_range(8191)) : int'($urandom_range(600, 1));
        ox  = int'($urandom_range(60000)) - 30000;
        oy  = int'($urandom_range(60000)) - 30000;
        oz  = int'($urandom_range(60000)) - 30000;
        r = mk_ray(ox, oy, oz, 0, 0, 0, 0, 0, 0, rad);
        r.dir_x = clamp_coord(ux * 16384.0);
        r.dir_y = clamp_coord(uy * 16384.0);
        r.dir_z = clamp_coord(uz * 16384.0);
        case (kind)
            RAY_AIMED: begin
                reach   = real'($urandom_range(40000));
                r.ctr_x = clamp_coord(ox + ux * reach + jitter(rad + rad / 4));
                r.ctr_y = clamp_coord(oy + uy * reach + jitter(rad + rad / 4));
                r.ctr_z = clamp_coord(oz + uz * reach + jitter(rad + rad / 4));
            end
            RAY_INSIDE: begin
                r.ctr_x = clamp_coord(real'(ox + jitter(rad / 2)));
                r.ctr_y = clamp_coord(real'(oy + jitter(rad / 2)));
                r.ctr_z = clamp_coord(real'(oz + jitter(rad / 2)));
            end
            RAY_BEHIND: begin
                reach   = real'($urandom_range(40000, rad + 100));
                r.ctr_x = clamp_coord(ox - ux * reach + jitter(rad));
                r.ctr_y = clamp_coord(oy - uy * reach + jitter(rad));
                r.ctr_z = clamp_coord(oz - uz * reach + jitter(rad));
            end
            default: begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                // keep the unit direction half the time
                if ($urandom_range(1) == 0) begin
                    raw[RADIUS_W + 3*COORD_W +: 3*COORD_W] = {r.dir_x, r.dir_y, r.dir_z};
                end
                r = raw[$bits(ray_t)-1:0];
            end
        endcase
        return r;
    endfunction

    // drive one ray transaction, called and returning at a falling edge
    task automatic send_ray(input ray_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            ray_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        ray_ch.valid <= 1'b1;
        {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
         ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z,
         ray_ch.center_x, ray_ch.center_y, ray_ch.center_z,
         ray_ch.sphere_radius} <= r;
        do @(posedge i_clk); while (!ray_ch.ready);
        rays_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count, input bit hold);
        send_idle_pct = idle;
        stall_pct     = stall;
        if (hold) begin
            long_hold_req = 1'b1;
        end
        repeat (count) send_ray(random_ray());
    endtask

    // reset, directed rays, random phases, drain and verdict
    initial begin
        i_rst_n      = 1'b0;
        ray_ch.valid = 1'b0;
        {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
         ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z,
         ray_ch.center_x, ray_ch.center_y, ray_ch.center_z,
         ray_ch.sphere_radius} = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // straight hit, miss, sphere behind, origin inside
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 1000, 0, 0, 100));
        send_ray(mk_ray(0, 0, 0, 0, 16384, 0, 1000, 0, 0, 100));
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, -1000, 0, 0, 100));
        send_ray(mk_ray(500, -200, 300, 0, 0, -16384, 500, -200, 300, 500));
        // point sphere hit and miss, tangent ray
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 100, 0, 0, 0));
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 100, 1, 0, 0));
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 1000, 100, 0, 100));
        // coordinate and radius extremes
        send_ray(mk_ray(-32768, -32768, -32768, 9459, 9459, 9459, 32767, 32767, 32767, 8191));
        send_ray(mk_ray(32767, 32767, 32767, -9459, -9459, -9459, -32768, -32768, -32768, 8191));
        // direction far from unit length, both signs
        send_ray(mk_ray(32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768,
                        8191));
        send_ray(mk_ray(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 8191));
        send_ray(mk_ray(-32768, -32768, 32767, 16384, 16384, -16384, 0, 0, 0, 8191));
        // zero direction, then axis directions, all from inside
        send_ray(mk_ray(10, 20, 30, 0, 0, 0, 0, 0, 0, 8191));
        send_ray(mk_ray(0, 0, 5000, 0, 0, -16384, 0, 0, 0, 8191));
        send_ray(mk_ray(0, 0, 0, -16384, 0, 0, 1, 0, 0, 8191));
        // dot of minus one floors to minus one, hit at distance zero
        send_ray(mk_ray(0, 0, 0, 1, 0, 0, 1, 0, 0, 1));
        // origin on the surface heading out
        send_ray(mk_ray(100, 0, 0, 16384, 0, 0, 0, 0, 0, 100));

        run_phase(0, 0, 150, 1'b0);
        run_phase(77, 0, 150, 1'b0);
        run_phase(0, 77, 150, 1'b0);
        run_phase(36, 36, 150, 1'b0);
        // full rate input against a long output hold, pipeline fills and stalls
        run_phase(0, 0, 100, 1'b1);

        ray_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d rays (directed, aimed, inside, behind, noise), %0d results, %0d hits",
                 rays_sent, checked, hits);
        $display("Summary: phases without gaps, with sender gaps, receiver stalls, both, long hold");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
